// ----- rtl/clb_pkg.sv -----
`default_nettype none

package clb_pkg;

  // Command codes on func_i
  typedef enum logic [1:0] {
    FUNC_INIT    = 2'd0,
    FUNC_PUT     = 2'd1,
    FUNC_REFRESH = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RS_MASK        = 2'd0,
    CFG_ENABLE_MASK    = 2'd1,
    CFG_BACKLIGHT_MASK = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INIT = 4'b0010,
    ST_CMD  = 4'b0100,
    ST_DATA = 4'b1000
  } state_e;

  localparam logic [7:0]  CMD_ROW0      = 8'h80;
  localparam logic [7:0]  CMD_ROW1      = 8'hC0;
  localparam logic [7:0]  CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0]  CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0]  CMD_ENTRY     = 8'h06;
  localparam logic [7:0]  NIB_WAKE      = 8'h03;
  localparam logic [7:0]  NIB_4BIT      = 8'h02;
  localparam logic [7:0]  CHAR_SPACE    = 8'h20;
  localparam logic [12:0] WAIT_LONG_US  = 13'd4500;
  localparam logic [12:0] WAIT_SHORT_US = 13'd150;
  localparam logic [2:0]  BYTES_NIBBLE  = 3'd3;
  localparam logic [2:0]  BYTES_BYTE    = 3'd6;
  localparam logic [2:0]  INIT_LAST     = 3'd6;

  // Expander bit masks
  typedef struct packed {
    logic [7:0] rs;
    logic [7:0] enable;
    logic [7:0] backlight;
  } cfg_t;

  // One frame to send
  typedef struct packed {
    logic        vld;
    logic [7:0]  value;
    logic        is_byte;
    logic        is_data;
    logic [12:0] wait_us;
    logic        last;
  } emit_t;

endpackage

`default_nettype wire

// ----- rtl/char_lcd_backpack_refresher.sv -----
`default_nettype none

// Channel   Handshake             Payload
// command   start / busy          func_i, row_i, column_i, character_i
// result    out_strobe_o          frame_o, byte_count_o, wait_us_o, last_o
// config    cfg_we_i              cfg_index_i, cfg_wdata_i
//
// Initialize sends 7 frames, one a cycle.
// Refresh sends ROWS*(COLUMNS+1) frames (34 by default): one frame a cycle,
// paced by the single read port of the character store.
// Put character writes the store without leaving idle, so busy stays low.
// Reset sets the masks to their defaults and marks every store entry as space.
// Results cannot be held off: each strobe lasts one cycle.

module char_lcd_backpack_refresher import clb_pkg::*; #(
  parameter int unsigned COLUMNS = 16,
  parameter int unsigned ROWS    = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func_i,
  input  wire logic        row_i,
  input  wire logic [3:0]  column_i,
  input  wire logic [7:0]  character_i,
  output logic             out_strobe_o,
  output logic [47:0]      frame_o,
  output logic [2:0]       byte_count_o,
  output logic [12:0]      wait_us_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  localparam int unsigned DEPTH  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned COL_W  = $clog2(COLUMNS);

  state_e             state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic               row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  cfg_t               cfg_q;
  emit_t              req;
  logic               accept;
  logic               put_ok;
  logic               clear;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign put_ok = (32'(row_i) < ROWS) && (32'(column_i) < COLUMNS);
  assign wr_addr = (row_i ? ADDR_W'(COLUMNS) : '0) + ADDR_W'(column_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rs        <= 8'd1;
      cfg_q.enable    <= 8'd4;
      cfg_q.backlight <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RS_MASK:        cfg_q.rs        <= cfg_wdata_i;
        CFG_ENABLE_MASK:    cfg_q.enable    <= cfg_wdata_i;
        CFG_BACKLIGHT_MASK: cfg_q.backlight <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_d      = addr_q;
    req         = '0;
    clear       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FUNC_INIT: begin
              clear   = 1'b1;
              step_d  = '0;
              state_d = ST_INIT;
            end
            FUNC_PUT: begin
              wr_en = put_ok;
            end
            FUNC_REFRESH: begin
              row_d   = 1'b0;
              addr_d  = '0;
              state_d = ST_CMD;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        req.vld = 1'b1;
        case (step_q)
          3'd0: begin
            req.value   = NIB_WAKE;
            req.wait_us = WAIT_LONG_US;
          end
          3'd1, 3'd2: begin
            req.value   = NIB_WAKE;
            req.wait_us = WAIT_SHORT_US;
          end
          3'd3: begin
            req.value   = NIB_4BIT;
            req.wait_us = WAIT_SHORT_US;
          end
          3'd4: begin
            req.value   = CMD_FUNC_SET;
            req.is_byte = 1'b1;
          end
          3'd5: begin
            req.value   = CMD_DISP_ON;
            req.is_byte = 1'b1;
          end
          default: begin
            req.value   = CMD_ENTRY;
            req.is_byte = 1'b1;
          end
        endcase
        if (step_q == INIT_LAST) begin
          req.last = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_CMD: begin
        // Send the cursor command while the row's first character is read
        req.vld     = 1'b1;
        req.is_byte = 1'b1;
        req.value   = row_q ? CMD_ROW1 : CMD_ROW0;
        rd_en       = 1'b1;
        rd_addr     = addr_q;
        col_d       = '0;
        state_d     = ST_DATA;
      end
      ST_DATA: begin
        req.vld     = 1'b1;
        req.is_byte = 1'b1;
        req.is_data = 1'b1;
        req.value   = rd_data;
        if (col_q != COL_W'(COLUMNS - 1)) begin
          rd_en   = 1'b1;
          rd_addr = addr_q + 1'b1;
          addr_d  = addr_q + 1'b1;
          col_d   = col_q + 1'b1;
        end else if (row_q != 1'(ROWS - 1)) begin
          row_d   = 1'b1;
          addr_d  = addr_q + 1'b1;
          state_d = ST_CMD;
        end else begin
          req.last = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      row_q   <= 1'b0;
      col_q   <= '0;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      row_q   <= row_d;
      col_q   <= col_d;
      addr_q  <= addr_d;
    end
  end

  clb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (character_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  clb_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .masks_i      (cfg_q),
    .req_i        (req),
    .strobe_o     (out_strobe_o),
    .frame_o      (frame_o),
    .byte_count_o (byte_count_o),
    .wait_us_o    (wait_us_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // The final transfer of a command shows once the sequencer is idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && last_o |-> !busy)
    else $error("last frame while sequencer still busy");

  // Frames are nibble or byte sized
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> (byte_count_o == BYTES_NIBBLE || byte_count_o == BYTES_BYTE))
    else $error("bad byte count");

  // A command that sends frames makes the sequencer busy, and its first strobe then follows from the frame register
  a_start_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (func_i == FUNC_INIT || func_i == FUNC_REFRESH) |=> busy ##1 out_strobe_o)
    else $error("accepted command did not start frames");

  // Every strobe comes from a request made while the sequencer was busy in the cycle before
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(busy))
    else $error("frame strobe without active command");
`endif

endmodule

`default_nettype wire

// ----- rtl/clb_store.sv -----
`default_nettype none

module clb_store import clb_pkg::*; #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [7:0]        wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]             rd_data_o
);

  logic [7:0]       mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       rd_data_q;
  logic             rd_valid_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Track written entries; clear drops all of them back to space
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_addr_i];
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : CHAR_SPACE;

endmodule

`default_nettype wire

// ----- rtl/clb_frame.sv -----
`default_nettype none

module clb_frame import clb_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   masks_i,
  input  wire emit_t  req_i,
  output logic        strobe_o,
  output logic [47:0] frame_o,
  output logic [2:0]  byte_count_o,
  output logic [12:0] wait_us_o,
  output logic        last_o
);

  logic [7:0]  rs_sel;
  logic [3:0]  hi_nib;
  logic [7:0]  hi_b, hi_s, lo_b, lo_s;
  logic [47:0] frame_d;
  logic        strobe_q;
  logic [47:0] frame_q;
  logic [2:0]  count_q;
  logic [12:0] wait_q;
  logic        last_q;

  // Build enable low, high, low bytes for each nibble
  always_comb begin
    rs_sel  = req_i.is_data ? masks_i.rs : 8'h00;
    hi_nib  = req_i.is_byte ? req_i.value[7:4] : req_i.value[3:0];
    hi_b    = {hi_nib, 4'h0} | masks_i.backlight | rs_sel;
    hi_s    = hi_b | masks_i.enable;
    lo_b    = {req_i.value[3:0], 4'h0} | masks_i.backlight | rs_sel;
    lo_s    = lo_b | masks_i.enable;
    frame_d = req_i.is_byte ? {hi_b, hi_s, hi_b, lo_b, lo_s, lo_b}
                            : {hi_b, hi_s, hi_b, 24'h000000};
  end

  // Strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= req_i.vld;
    end
  end

  // Hold payload for the strobe cycle
  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      frame_q <= frame_d;
      count_q <= req_i.is_byte ? BYTES_BYTE : BYTES_NIBBLE;
      wait_q  <= req_i.wait_us;
      last_q  <= req_i.last;
    end
  end

  assign strobe_o     = strobe_q;
  assign frame_o      = frame_q;
  assign byte_count_o = count_q;
  assign wait_us_o    = wait_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb import clb_pkg::*;;

  localparam int unsigned COLS        = 16;
  localparam int unsigned NROWS       = 2;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [7:0] RS_DEFAULT = 8'h01;
  localparam logic [7:0] EN_DEFAULT = 8'h04;
  localparam logic [7:0] BL_DEFAULT = 8'h08;

  typedef struct {
    logic [47:0] frame;
    logic [2:0]  count;
    logic [12:0] wait_us;
    logic        last;
  } frame_due_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  logic [1:0]  func_i      = '0;
  logic        row_i       = 1'b0;
  logic [3:0]  column_i    = '0;
  logic [7:0]  character_i = '0;
  logic        out_strobe_o;
  logic [47:0] frame_o;
  logic [2:0]  byte_count_o;
  logic [12:0] wait_us_o;
  logic        last_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_wdata_i = '0;

  // Shadow of the display store and expander masks
  logic [7:0]  screen [NROWS*COLS];
  logic [7:0]  rs_bits = RS_DEFAULT;
  logic [7:0]  en_bits = EN_DEFAULT;
  logic [7:0]  bl_bits = BL_DEFAULT;

  frame_due_t  frames_due [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle_pct = 0;

  char_lcd_backpack_refresher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .character_i  (character_i),
    .out_strobe_o (out_strobe_o),
    .frame_o      (frame_o),
    .byte_count_o (byte_count_o),
    .wait_us_o    (wait_us_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Build the enable low / high / low byte triplet for one nibble
  function automatic logic [23:0] strobe_triplet(logic [3:0] nib, bit is_data);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = {nib, 4'h0} | bl_bits | (is_data ? rs_bits : 8'h00);
    hi = lo | en_bits;
    return {lo, hi, lo};
  endfunction

  function automatic void push_nibble(logic [3:0] nib, logic [12:0] wait_us);
    frame_due_t f;
    f.frame   = {strobe_triplet(nib, 1'b0), 24'h0};
    f.count   = BYTES_NIBBLE;
    f.wait_us = wait_us;
    f.last    = 1'b0;
    frames_due.push_back(f);
  endfunction

  function automatic void push_byte(logic [7:0] value, bit is_data, bit is_last);
    frame_due_t f;
    f.frame   = {strobe_triplet(value[7:4], is_data), strobe_triplet(value[3:0], is_data)};
    f.count   = BYTES_BYTE;
    f.wait_us = '0;
    f.last    = is_last;
    frames_due.push_back(f);
  endfunction

  // Advance the shadow state by one accepted command and queue its frames
  function automatic void apply_cmd(func_e f, logic row, logic [3:0] col, logic [7:0] ch);
    case (f)
      FUNC_INIT: begin
        push_nibble(NIB_WAKE[3:0], WAIT_LONG_US);
        push_nibble(NIB_WAKE[3:0], WAIT_SHORT_US);
        push_nibble(NIB_WAKE[3:0], WAIT_SHORT_US);
        push_nibble(NIB_4BIT[3:0], WAIT_SHORT_US);
        push_byte(CMD_FUNC_SET, 1'b0, 1'b0);
        push_byte(CMD_DISP_ON, 1'b0, 1'b0);
        push_byte(CMD_ENTRY, 1'b0, 1'b1);
        foreach (screen[i]) screen[i] = CHAR_SPACE;
      end
      FUNC_PUT: begin
        screen[row*COLS + col] = ch;
      end
      FUNC_REFRESH: begin
        for (int r = 0; r < NROWS; r++) begin
          push_byte(r == 0 ? CMD_ROW0 : CMD_ROW1, 1'b0, 1'b0);
          for (int c = 0; c < COLS; c++)
            push_byte(screen[r*COLS + c], 1'b1, (r == NROWS-1) && (c == COLS-1));
        end
      end
      default: ;
    endcase
  endfunction

  // Present one command, holding it until the block takes the transfer
  task automatic send_cmd(func_e f, logic row, logic [3:0] col, logic [7:0] ch);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    func_i      <= f;
    row_i       <= row;
    column_i    <= col;
    character_i <= ch;
    do begin
      @(posedge clk_i);
    end while (busy);
    apply_cmd(f, row, col, ch);
  endtask

  // Drop start and wait until every expected frame is out and the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (frames_due.size() != 0 || busy) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Write one mask, then leave the port idle before returning
  task automatic write_mask(cfg_idx_e idx, logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_RS_MASK:        rs_bits = value;
      CFG_ENABLE_MASK:    en_bits = value;
      CFG_BACKLIGHT_MASK: bl_bits = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Defaults after reset: blank screen, then wake-up sequence
  task automatic test_reset_state();
    send_cmd(FUNC_REFRESH, 1'b0, 4'd0, 8'h00);
    send_cmd(FUNC_INIT, 1'b1, 4'd15, 8'hFF);
    send_cmd(FUNC_REFRESH, 1'b1, 4'd15, 8'hFF);
  endtask

  // Corners of the screen with extreme character codes
  task automatic test_put_corners();
    send_cmd(FUNC_PUT, 1'b0, 4'd0, 8'h00);
    send_cmd(FUNC_PUT, 1'b0, 4'd15, 8'hFF);
    send_cmd(FUNC_PUT, 1'b1, 4'd0, 8'hA5);
    send_cmd(FUNC_PUT, 1'b1, 4'd15, 8'h5A);
    send_cmd(FUNC_REFRESH, 1'b0, 4'd0, 8'h00);
  endtask

  // Unused code must leave the store alone and send nothing
  task automatic test_unused_func();
    send_cmd(FUNC_NONE, 1'b1, 4'd7, 8'h3C);
    send_cmd(FUNC_NONE, 1'b0, 4'd8, 8'hC3);
    send_cmd(FUNC_REFRESH, 1'b0, 4'd0, 8'h00);
  endtask

  // Mask extremes, the spare index, then a random setting
  task automatic test_masks();
    drain();
    write_mask(CFG_RS_MASK, 8'h00);
    write_mask(CFG_ENABLE_MASK, 8'h00);
    write_mask(CFG_BACKLIGHT_MASK, 8'h00);
    send_cmd(FUNC_REFRESH, 1'b0, 4'd0, 8'h00);
    send_cmd(FUNC_INIT, 1'b0, 4'd0, 8'h00);
    drain();
    write_mask(CFG_RS_MASK, 8'hFF);
    write_mask(CFG_ENABLE_MASK, 8'hFF);
    write_mask(CFG_BACKLIGHT_MASK, 8'hFF);
    write_mask(CFG_UNUSED, 8'h55);
    send_cmd(FUNC_PUT, 1'b1, 4'd9, 8'h81);
    send_cmd(FUNC_REFRESH, 1'b1, 4'd9, 8'h81);
    send_cmd(FUNC_INIT, 1'b1, 4'd9, 8'h81);
    drain();
    write_mask(CFG_RS_MASK, 8'($urandom));
    write_mask(CFG_ENABLE_MASK, 8'($urandom));
    write_mask(CFG_BACKLIGHT_MASK, 8'($urandom));
    send_cmd(FUNC_REFRESH, 1'b0, 4'd0, 8'h00);
  endtask

  // Mostly puts with regular refreshes, some re-inits and unused codes
  task automatic test_random_traffic(int unsigned n_cmds, int unsigned idle_pct);
    int unsigned pick;
    drain();
    write_mask(CFG_RS_MASK, 8'($urandom));
    write_mask(CFG_ENABLE_MASK, 8'($urandom));
    write_mask(CFG_BACKLIGHT_MASK, 8'($urandom));
    sender_idle_pct = idle_pct;
    for (int unsigned k = 0; k < n_cmds; k++) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_cmd(FUNC_PUT, 1'($urandom), 4'($urandom), 8'($urandom));
      else if (pick < 80)
        send_cmd(FUNC_REFRESH, 1'($urandom), 4'($urandom), 8'($urandom));
      else if (pick < 90)
        send_cmd(FUNC_INIT, 1'($urandom), 4'($urandom), 8'($urandom));
      else
        send_cmd(FUNC_NONE, 1'($urandom), 4'($urandom), 8'($urandom));
    end
  endtask

  // Compare each strobed frame with the oldest expectation
  always @(posedge clk_i) begin : check_frames
    frame_due_t want;
    if (rst_ni && out_strobe_o) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame %h", frame_o);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (frame_o !== want.frame) begin
          $error("frame: expected %h, got %h", want.frame, frame_o);
          errors++;
        end
        if (byte_count_o !== want.count) begin
          $error("byte_count: expected %0d, got %0d", want.count, byte_count_o);
          errors++;
        end
        if (wait_us_o !== want.wait_us) begin
          $error("wait_us: expected %0d, got %0d", want.wait_us, wait_us_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("char_lcd_backpack_refresher test failed");
      $finish;
    end
  end

  initial begin
    foreach (screen[i]) screen[i] = CHAR_SPACE;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_put_corners();
    test_unused_func();
    test_masks();
    test_random_traffic(167, 37);
    test_random_traffic(167, 59);
    test_random_traffic(166, 0);
    drain();

    if (frames_due.size() != 0) begin
      $error("%0d expected frames never arrived", frames_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("char_lcd_backpack_refresher test passed");
    end else begin
      $display("char_lcd_backpack_refresher test failed");
    end
    $finish;
  end

endmodule

// ----- char_lcd_backpack_refresher.f -----
rtl/clb_pkg.sv
rtl/clb_store.sv
rtl/clb_frame.sv
rtl/char_lcd_backpack_refresher.sv
bench/tb.sv
